// File: rtl/hmr_pkg.sv
`default_nettype none

package hmr_pkg;

    localparam int AREA_W     = 44;
    localparam int HEIGHT_IN_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_WIDTH,
        S_MUL_LO,
        S_MUL_HI,
        S_SCORE,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic clear;
        logic mul_lo;
        logic mul_hi;
        logic finish;
    } score_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/histogram_max_rectangle_unit.sv
`default_nettype none

// Channel   Dir  tdata (low bit up)            tlast     tuser
// s_*       in   height[31:0]                  last_bar  -
// m_*       out  max_area[43:0], 4 zero bits   -         overflow
//
// A bar that pushes without popping passes S_IDLE and S_CMP. Each popped
// stack entry adds a read of the entry below it from the stack memory, then two
// passes through the shared half-height multiplier and one add, saturate and
// compare step. The final bar flushes the remaining stack entry by entry, then
// loads the result. Reset is synchronous and empties the stack;
// the stack memory itself is not cleared. The result waits in an output
// register, so a stalled m_tready only holds the block at the end of the next
// histogram.
module histogram_max_rectangle_unit
    import hmr_pkg::*;
#(
    parameter int MAX_BARS    = 4096,
    parameter int HEIGHT_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // height[31:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // max_area[43:0], zero fill[47:44]
    output logic      [0:0]  m_tuser    // overflow
);

    localparam int POS_W  = $clog2(MAX_BARS);
    localparam int CNT_W  = $clog2(MAX_BARS + 1);
    localparam int HIN_W  = (HEIGHT_BITS < HEIGHT_IN_W) ? HEIGHT_BITS : HEIGHT_IN_W;
    localparam int ENTRY_W = HEIGHT_BITS + POS_W;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       depth_reg, depth_next;
    logic [CNT_W-1:0]       bar_count_reg, bar_count_next;
    logic [HEIGHT_BITS-1:0] top_h_reg, top_h_next;
    logic [HEIGHT_BITS-1:0] cur_h_reg, cur_h_next;
    logic                   cur_last_reg, cur_last_next;
    logic                   flush_reg, flush_next;
    logic                   ovf_reg, ovf_next;
    logic [HEIGHT_BITS-1:0] mult_h_reg, mult_h_next;
    logic [CNT_W-1:0]       w_reg, w_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [AREA_W-1:0]      m_area_reg, m_area_next;
    logic                   m_ovf_reg, m_ovf_next;

    logic                   wr_en;
    logic                   rd_en;
    logic [POS_W-1:0]       wr_addr;
    logic [CNT_W-1:0]       rd_addr_full;
    logic [POS_W-1:0]       rd_addr;
    logic [ENTRY_W-1:0]     wr_data;
    logic [ENTRY_W-1:0]     rd_data;
    logic [POS_W-1:0]       below_pos;
    score_ctrl_t            sc;
    logic [AREA_W-1:0]      best_area;

    assign wr_addr      = depth_reg[POS_W-1:0];
    assign wr_data      = {cur_h_reg, bar_count_reg[POS_W-1:0]};
    assign rd_addr_full = depth_reg - CNT_W'(2);
    assign rd_addr      = rd_addr_full[POS_W-1:0];
    assign below_pos    = rd_data[POS_W-1:0];

    hmr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BARS)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hmr_score #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .CNT_W       (CNT_W)
    ) u_score (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sc),
        .bar_h     (mult_h_reg),
        .bar_w     (w_reg),
        .best_area (best_area)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            bar_count_reg <= '0;
            flush_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            bar_count_reg <= bar_count_next;
            flush_reg     <= flush_next;
            ovf_reg       <= ovf_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_h_reg    <= top_h_next;
        cur_h_reg    <= cur_h_next;
        cur_last_reg <= cur_last_next;
        mult_h_reg   <= mult_h_next;
        w_reg        <= w_next;
        m_area_reg   <= m_area_next;
        m_ovf_reg    <= m_ovf_next;
    end

    always_comb begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        bar_count_next = bar_count_reg;
        top_h_next     = top_h_reg;
        cur_h_next     = cur_h_reg;
        cur_last_next  = cur_last_reg;
        flush_next     = flush_reg;
        ovf_next       = ovf_reg;
        mult_h_next    = mult_h_reg;
        w_next         = w_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_area_next    = m_area_reg;
        m_ovf_next     = m_ovf_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        sc             = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cur_h_next    = HEIGHT_BITS'(s_tdata[HIN_W-1:0]);
                    cur_last_next = s_tlast;
                    if (bar_count_reg >= CNT_W'(MAX_BARS)) begin
                        ovf_next = 1'b1;
                        if (s_tlast) begin
                            flush_next = 1'b1;
                            state_next = S_FLUSH;
                        end
                    end else begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if ((depth_reg != '0) && (top_h_reg > cur_h_reg)) begin
                    rd_en       = 1'b1;
                    mult_h_next = top_h_reg;
                    state_next  = S_WIDTH;
                end else begin
                    wr_en          = 1'b1;
                    top_h_next     = cur_h_reg;
                    depth_next     = depth_reg + CNT_W'(1);
                    bar_count_next = bar_count_reg + CNT_W'(1);
                    if (cur_last_reg) begin
                        flush_next = 1'b1;
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_WIDTH: begin
                if (depth_reg == CNT_W'(1)) begin
                    w_next = bar_count_reg;
                end else begin
                    w_next = bar_count_reg - CNT_W'(below_pos) - CNT_W'(1);
                end
                top_h_next = rd_data[ENTRY_W-1:POS_W];
                depth_next = depth_reg - CNT_W'(1);
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                sc.mul_lo  = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                sc.mul_hi  = 1'b1;
                state_next = S_SCORE;
            end
            S_SCORE: begin
                sc.finish  = 1'b1;
                state_next = flush_reg ? S_FLUSH : S_CMP;
            end
            S_FLUSH: begin
                if (depth_reg != '0) begin
                    rd_en       = 1'b1;
                    mult_h_next = top_h_reg;
                    state_next  = S_WIDTH;
                end else if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_area_next    = best_area;
                    m_ovf_next     = ovf_reg;
                    sc.clear       = 1'b1;
                    depth_next     = '0;
                    bar_count_next = '0;
                    ovf_next       = 1'b0;
                    flush_next     = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {4'b0000, m_area_reg};
    assign m_tuser[0] = m_ovf_reg;

    // The stack never holds more entries than bars seen in this histogram.
    a_depth_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= bar_count_reg)
        else $error("stack depth exceeds bar count");

    a_count_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        bar_count_reg <= CNT_W'(MAX_BARS))
        else $error("bar count exceeds capacity");

    // A pop is only started on a non-empty stack.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WIDTH) |-> (depth_reg != '0))
        else $error("pop from empty stack");

    // A new result leaves the state cleared for the next histogram.
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (depth_reg == '0) && (bar_count_reg == '0)
                                && (state_reg == S_IDLE) && !ovf_reg)
        else $error("state not cleared after result");

endmodule

`default_nettype wire

// File: rtl/hmr_ram.sv
`default_nettype none

module hmr_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/hmr_score.sv
`default_nettype none

module hmr_score
    import hmr_pkg::*;
#(
    parameter int HEIGHT_BITS = 32,
    parameter int CNT_W       = 13
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire score_ctrl_t            ctrl,
    input  wire logic [HEIGHT_BITS-1:0] bar_h,
    input  wire logic [CNT_W-1:0]       bar_w,
    output logic      [AREA_W-1:0]      best_area
);

    localparam int HALF   = (HEIGHT_BITS + 1) / 2;
    localparam int MP_W   = HALF + CNT_W;
    localparam int PROD_W = HEIGHT_BITS + CNT_W;
    localparam int SUM_W  = (PROD_W > AREA_W) ? PROD_W : AREA_W + 1;

    logic [HALF-1:0]   operand;
    logic [MP_W-1:0]   product;
    logic [MP_W-1:0]   lo_reg;
    logic [MP_W-1:0]   hi_reg;
    logic [SUM_W-1:0]  sum;
    logic [AREA_W-1:0] area;
    logic [AREA_W-1:0] best_reg;
    logic [AREA_W-1:0] best_next;

    // One multiplier serves both halves of the height, one half per cycle.
    assign operand = ctrl.mul_hi ? HALF'(bar_h[HEIGHT_BITS-1:HALF]) : bar_h[HALF-1:0];
    assign product = MP_W'(operand) * MP_W'(bar_w);

    always_ff @(posedge aclk) begin
        if (ctrl.mul_lo) begin
            lo_reg <= product;
        end
        if (ctrl.mul_hi) begin
            hi_reg <= product;
        end
    end

    assign sum  = SUM_W'(lo_reg) + (SUM_W'(hi_reg) << HALF);
    assign area = (|sum[SUM_W-1:AREA_W]) ? {AREA_W{1'b1}} : sum[AREA_W-1:0];

    always_comb begin
        best_next = best_reg;
        if (ctrl.clear) begin
            best_next = '0;
        end else if (ctrl.finish && (area > best_reg)) begin
            best_next = area;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg <= '0;
        end else begin
            best_reg <= best_next;
        end
    end

    assign best_area = best_reg;

endmodule

`default_nettype wire
